[rtl/cte_pkg.sv]
package cte_pkg;

  // Output encoding selected by the configuration register.
  typedef enum logic [2:0] {
    ENC_ANSI    = 3'd0,
    ENC_UTF8    = 3'd1,
    ENC_UTF16LE = 3'd2,
    ENC_UTF16BE = 3'd3,
    ENC_UTF32LE = 3'd4,
    ENC_UTF32BE = 3'd5
  } encoding_t;

  localparam encoding_t ENCODING_RESET = ENC_UTF8;

  // Range limits of the variable-length encodings.
  localparam logic [31:0] UTF8_MAX_1BYTE = 32'h0000_007F;
  localparam logic [31:0] UTF8_MAX_2BYTE = 32'h0000_07FF;
  localparam logic [31:0] BMP_MAX        = 32'h0000_FFFF;
  localparam logic [31:0] UNICODE_MAX    = 32'h0010_FFFF;
  localparam logic [20:0] SUPP_OFFSET    = 21'h01_0000;

  // Surrogate unit prefixes: high 0xD800, low 0xDC00.
  localparam logic [5:0] SURR_HI_PREFIX = 6'b110110;
  localparam logic [5:0] SURR_LO_PREFIX = 6'b110111;

  localparam logic [2:0] MAX_BYTES = 3'd4;

  // One encoded result: bytes in stream order and the valid byte count.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
  } enc_result_t;

endpackage

[rtl/cte_encode_core.sv]
module cte_encode_core
  import cte_pkg::*;
(
  input  logic [31:0] code_point,
  input  encoding_t   encoding,
  output enc_result_t result
);

  logic [20:0] supp_v;
  logic [15:0] unit_hi;
  logic [15:0] unit_lo;

  // Surrogate pair units for supplementary-plane code points.
  always_comb begin
    supp_v  = code_point[20:0] - SUPP_OFFSET;
    unit_hi = {SURR_HI_PREFIX, supp_v[19:10]};
    unit_lo = {SURR_LO_PREFIX, supp_v[9:0]};
  end

  // Byte assembly per encoding; unused bytes stay zero.
  always_comb begin
    result = '0;
    case (encoding)
      ENC_ANSI: begin
        result.bytes[0] = code_point[7:0];
        result.count    = 3'd1;
      end
      ENC_UTF8: begin
        if (code_point <= UTF8_MAX_1BYTE) begin
          result.bytes[0] = code_point[7:0];
          result.count    = 3'd1;
        end else if (code_point <= UTF8_MAX_2BYTE) begin
          result.bytes[0] = {3'b110, code_point[10:6]};
          result.bytes[1] = {2'b10, code_point[5:0]};
          result.count    = 3'd2;
        end else if (code_point <= BMP_MAX) begin
          result.bytes[0] = {4'b1110, code_point[15:12]};
          result.bytes[1] = {2'b10, code_point[11:6]};
          result.bytes[2] = {2'b10, code_point[5:0]};
          result.count    = 3'd3;
        end else if (code_point <= UNICODE_MAX) begin
          result.bytes[0] = {5'b11110, code_point[20:18]};
          result.bytes[1] = {2'b10, code_point[17:12]};
          result.bytes[2] = {2'b10, code_point[11:6]};
          result.bytes[3] = {2'b10, code_point[5:0]};
          result.count    = MAX_BYTES;
        end
      end
      ENC_UTF16LE: begin
        if (code_point <= BMP_MAX) begin
          result.bytes[0] = code_point[7:0];
          result.bytes[1] = code_point[15:8];
          result.count    = 3'd2;
        end else if (code_point <= UNICODE_MAX) begin
          result.bytes[0] = unit_hi[7:0];
          result.bytes[1] = unit_hi[15:8];
          result.bytes[2] = unit_lo[7:0];
          result.bytes[3] = unit_lo[15:8];
          result.count    = MAX_BYTES;
        end
      end
      ENC_UTF16BE: begin
        if (code_point <= BMP_MAX) begin
          result.bytes[0] = code_point[15:8];
          result.bytes[1] = code_point[7:0];
          result.count    = 3'd2;
        end else if (code_point <= UNICODE_MAX) begin
          result.bytes[0] = unit_hi[15:8];
          result.bytes[1] = unit_hi[7:0];
          result.bytes[2] = unit_lo[15:8];
          result.bytes[3] = unit_lo[7:0];
          result.count    = MAX_BYTES;
        end
      end
      ENC_UTF32LE: begin
        result.bytes = code_point;
        result.count = MAX_BYTES;
      end
      ENC_UTF32BE: begin
        result.bytes[0] = code_point[31:24];
        result.bytes[1] = code_point[23:16];
        result.bytes[2] = code_point[15:8];
        result.bytes[3] = code_point[7:0];
        result.count    = MAX_BYTES;
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule

[rtl/codepoint_to_utf_encoder_top.sv]
// Each accepted item passes through the input register and then the result register to the outputs.
// Throughput: one code point per cycle; busy is always low since the encoder is a single pass.
// Each result is shown for one cycle with out_valid; the receiver cannot stall it.
// Reset (synchronous, rst_n low) clears the pipeline valid flags and sets the encoding to UTF-8.
module codepoint_to_utf_encoder_top
  import cte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_code_point,
  output logic        out_valid,
  output logic [7:0]  out_byte_0,
  output logic [7:0]  out_byte_1,
  output logic [7:0]  out_byte_2,
  output logic [7:0]  out_byte_3,
  output logic [2:0]  out_byte_count,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_encoding
);

  encoding_t   encoding_r;
  logic        in_valid_r;
  logic [31:0] code_point_r;
  logic        out_valid_r;
  enc_result_t result_r;
  enc_result_t result_nxt;

  assign busy = 1'b0;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      encoding_r <= ENCODING_RESET;
    end else if (cfg_we) begin
      encoding_r <= encoding_t'(cfg_encoding);
    end
  end

  // Input stage: capture each accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      code_point_r <= in_code_point;
    end
  end

  // Combinational encoder between the two register stages.
  cte_encode_core u_core (
    .code_point (code_point_r),
    .encoding   (encoding_r),
    .result     (result_nxt)
  );

  // Result stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte_0     = result_r.bytes[0];
  assign out_byte_1     = result_r.bytes[1];
  assign out_byte_2     = result_r.bytes[2];
  assign out_byte_3     = result_r.bytes[3];
  assign out_byte_count = result_r.count;

  // Every accepted item reaches the output through the input register and the result register.
  a_two_cycle_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid_r)
    else $error("accepted item did not produce a result two cycles later");

  // A result strobe always stems from a captured item.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(in_valid_r))
    else $error("result strobe without a captured item");

  // The byte count never exceeds four.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_byte_count <= MAX_BYTES))
    else $error("byte count out of range");

  // An unencodable item gives all-zero bytes.
  a_zero_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_byte_count == 3'd0) |-> (result_r.bytes == '0))
    else $error("nonzero bytes with zero byte count");

  // Bytes past a single-byte result are zero.
  a_single_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_byte_count == 3'd1) |->
      (out_byte_1 == 8'd0 && out_byte_2 == 8'd0 && out_byte_3 == 8'd0))
    else $error("stale bytes beyond a one-byte result");

endmodule

[verif/cte_checker.sv]
module cte_checker
  import cte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] in_code_point,
  input  logic        out_valid,
  input  logic [7:0]  out_byte_0,
  input  logic [7:0]  out_byte_1,
  input  logic [7:0]  out_byte_2,
  input  logic [7:0]  out_byte_3,
  input  logic [2:0]  out_byte_count,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_encoding,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted encoding, kept with its code point for the error report.
  typedef struct {
    logic [31:0] code_point;
    enc_result_t enc;
  } encoded_item_t;

  logic [2:0]    encoding_sel;
  encoded_item_t encoded_q[$];

  // Encodes one code point under the given encoding; unused bytes stay zero.
  function automatic enc_result_t encode_code_point(logic [31:0] cp, logic [2:0] sel);
    enc_result_t r;
    logic [31:0] v;
    logic [15:0] units[2];
    logic        big;
    r = '0;
    big = (sel == ENC_UTF16BE) || (sel == ENC_UTF32BE);
    case (sel)
      ENC_ANSI: begin
        r.bytes[0] = cp[7:0];
        r.count = 3'd1;
      end
      ENC_UTF8: begin
        if (cp <= UTF8_MAX_1BYTE) begin
          r.bytes[0] = cp[7:0];
          r.count = 3'd1;
        end else if (cp <= UTF8_MAX_2BYTE) begin
          r.bytes[0] = {3'b110, cp[10:6]};
          r.bytes[1] = {2'b10, cp[5:0]};
          r.count = 3'd2;
        end else if (cp <= BMP_MAX) begin
          r.bytes[0] = {4'b1110, cp[15:12]};
          r.bytes[1] = {2'b10, cp[11:6]};
          r.bytes[2] = {2'b10, cp[5:0]};
          r.count = 3'd3;
        end else if (cp <= UNICODE_MAX) begin
          r.bytes[0] = {5'b11110, cp[20:18]};
          r.bytes[1] = {2'b10, cp[17:12]};
          r.bytes[2] = {2'b10, cp[11:6]};
          r.bytes[3] = {2'b10, cp[5:0]};
          r.count = 3'd4;
        end
      end
      ENC_UTF16LE, ENC_UTF16BE: begin
        // A single unit up to the end of the BMP, a surrogate pair above it.
        units[0] = cp[15:0];
        units[1] = '0;
        if (cp <= BMP_MAX) begin
          r.count = 3'd2;
        end else if (cp <= UNICODE_MAX) begin
          v = cp - {11'd0, SUPP_OFFSET};
          units[0] = {SURR_HI_PREFIX, v[19:10]};
          units[1] = {SURR_LO_PREFIX, v[9:0]};
          r.count = 3'd4;
        end
        for (int u = 0; u < 2; u++) begin
          if (2 * u < r.count) begin
            r.bytes[2*u]   = big ? units[u][15:8] : units[u][7:0];
            r.bytes[2*u+1] = big ? units[u][7:0] : units[u][15:8];
          end
        end
      end
      ENC_UTF32LE, ENC_UTF32BE: begin
        for (int i = 0; i < 4; i++) begin
          if (big) begin
            r.bytes[3-i] = cp[8*i +: 8];
          end else begin
            r.bytes[i] = cp[8*i +: 8];
          end
        end
        r.count = 3'd4;
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  initial begin
    mismatches = 0;
    outstanding = 0;
    encoding_sel = ENCODING_RESET;
  end

  // Results are checked before new items are queued; the pipeline is two deep,
  // so an item never produces its result at the edge that accepts it.
  always @(posedge clk) begin
    encoded_item_t exp_item;
    enc_result_t   got;
    if (!rst_n) begin
      encoding_sel = ENCODING_RESET;
      encoded_q.delete();
    end else begin
      if (out_valid !== 1'b0) begin
        got.bytes[0] = out_byte_0;
        got.bytes[1] = out_byte_1;
        got.bytes[2] = out_byte_2;
        got.bytes[3] = out_byte_3;
        got.count = out_byte_count;
        if (encoded_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, bytes %h count %0d", $time, got.bytes,
                   got.count);
        end else begin
          exp_item = encoded_q.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (got.bytes[i] !== exp_item.enc.bytes[i]) begin
              mismatches++;
              $display("%0t: code point %h byte %0d expected %h actual %h", $time,
                       exp_item.code_point, i, exp_item.enc.bytes[i], got.bytes[i]);
            end
          end
          if (got.count !== exp_item.enc.count) begin
            mismatches++;
            $display("%0t: code point %h byte count expected %0d actual %0d", $time,
                     exp_item.code_point, exp_item.enc.count, got.count);
          end
        end
      end
      if (start && !busy) begin
        exp_item.code_point = in_code_point;
        exp_item.enc = encode_code_point(in_code_point, encoding_sel);
        encoded_q.push_back(exp_item);
      end
      // Register writes only happen while no item is in flight.
      if (cfg_we) begin
        encoding_sel = cfg_encoding;
      end
    end
    outstanding = encoded_q.size();
  end

endmodule

[verif/tb_codepoint_to_utf_encoder_top.sv]
module tb_codepoint_to_utf_encoder_top;
  import cte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Register values outside the defined encodings.
  localparam logic [2:0] ENC_RSVD_6 = 3'd6;
  localparam logic [2:0] ENC_RSVD_7 = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SEGMENTS = 16;
  localparam int SEGMENT_ITEMS = 119;

  localparam logic [2:0] ENC_ORDER[8] = '{ENC_ANSI, ENC_UTF16LE, ENC_UTF32BE, ENC_RSVD_6,
                                          ENC_UTF8, ENC_UTF16BE, ENC_UTF32LE, ENC_RSVD_7};
  localparam int IDLE_PHASES[4] = '{0, 65, 27, 0};

  // Range edges of the encodings, used with a small random offset.
  localparam logic [31:0] EDGE_POINTS[10] = '{32'h0, 32'h7F, 32'h7FF, 32'hD800, 32'hDFFF,
                                              32'hFFFF, 32'h10000, 32'h10FFFF,
                                              32'h110000, 32'hFFFF_FFFF};
  localparam logic [31:0] UTF8_DIRECTED[10] = '{32'h0, 32'h7F, 32'h80, 32'h7FF, 32'h800,
                                                32'hD800, 32'hFFFF, 32'h10000,
                                                32'h10FFFF, 32'h110000};

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_code_point;
  logic        out_valid;
  logic [7:0]  out_byte_0;
  logic [7:0]  out_byte_1;
  logic [7:0]  out_byte_2;
  logic [7:0]  out_byte_3;
  logic [2:0]  out_byte_count;
  logic        cfg_we;
  logic [2:0]  cfg_encoding;
  int          mismatches;
  int          outstanding;
  int          idle_pct;
  int          cycle_count;

  codepoint_to_utf_encoder_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_code_point (in_code_point),
    .out_valid     (out_valid),
    .out_byte_0    (out_byte_0),
    .out_byte_1    (out_byte_1),
    .out_byte_2    (out_byte_2),
    .out_byte_3    (out_byte_3),
    .out_byte_count(out_byte_count),
    .cfg_we        (cfg_we),
    .cfg_encoding  (cfg_encoding)
  );

  cte_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_code_point (in_code_point),
    .out_valid     (out_valid),
    .out_byte_0    (out_byte_0),
    .out_byte_1    (out_byte_1),
    .out_byte_2    (out_byte_2),
    .out_byte_3    (out_byte_3),
    .out_byte_count(out_byte_count),
    .cfg_we        (cfg_we),
    .cfg_encoding  (cfg_encoding),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block never delivers.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_codepoint_to_utf_encoder_top failed");
      $finish;
    end
  end

  // Code points weighted toward the range edges and the surrogate block.
  function automatic logic [31:0] pick_code_point();
    logic [31:0] cp;
    case ($urandom_range(0, 9))
      0: cp = $urandom_range(0, 32'h7F);
      1: cp = $urandom_range(32'h80, 32'h7FF);
      2: cp = $urandom_range(32'h800, 32'hFFFF);
      3: cp = $urandom_range(32'hD800, 32'hDFFF);
      4, 5: cp = $urandom_range(32'h10000, 32'h10FFFF);
      6: cp = EDGE_POINTS[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
      7: cp = $urandom_range(32'h110000, 32'h1FFFFF);
      default: cp = $urandom;
    endcase
    return cp;
  endfunction

  // Offers one item after an optional random gap and waits until it is taken.
  task automatic send_code_point(logic [31:0] cp);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      in_code_point <= $urandom;
    end
    @(negedge clk);
    start <= 1'b1;
    in_code_point <= cp;
    @(posedge clk iff !busy);
  endtask

  // Drains the pipeline, then writes the encoding register.
  task automatic set_encoding(logic [2:0] sel);
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_encoding <= sel;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_code_point = '0;
    cfg_we = 1'b0;
    cfg_encoding = ENC_UTF8;
    idle_pct = 0;
    cycle_count = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // The reset encoding is UTF-8: walk its range boundaries first.
    foreach (UTF8_DIRECTED[i]) send_code_point(UTF8_DIRECTED[i]);

    // Each other encoding sees a supplementary character and the all-ones value.
    for (int e = 0; e < 8; e++) begin
      if (ENC_ORDER[e] != ENC_UTF8) begin
        set_encoding(ENC_ORDER[e]);
        send_code_point(32'h1F600);
        send_code_point(32'hFFFF_FFFF);
      end
    end

    // Random segments rotate through every encoding; each idling pattern covers four consecutive segments.
    for (int s = 0; s < SEGMENTS; s++) begin
      set_encoding(ENC_ORDER[s % 8]);
      idle_pct = IDLE_PHASES[s / 4];
      for (int n = 0; n < SEGMENT_ITEMS; n++) send_code_point(pick_code_point());
    end

    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_codepoint_to_utf_encoder_top passed");
    end else begin
      $display("tb_codepoint_to_utf_encoder_top failed");
    end
    $finish;
  end

endmodule
